### rtl/core/inverse_affine_masked_pixel_map_macros.svh
// assertion macros for the inverse affine masked pixel map
// no dependencies; included by the top level
`ifndef INVERSE_AFFINE_MASKED_PIXEL_MAP_MACROS_SVH
`define INVERSE_AFFINE_MASKED_PIXEL_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IAMP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define IAMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define IAMP_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define IAMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### rtl/core/iamp_pkg.sv
// shared types and constants of the inverse affine masked pixel map
// no dependencies
package iamp_pkg;

    localparam int MASK_DIM_DEF       = 256;
    localparam int COORD_BITS_DEF     = 20;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int ORIGIN_FRAC        = 8;
    localparam logic [7:0] MASK_THRESHOLD = 8'd128;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_INV_A         = 3'd2,
        CFG_INV_B         = 3'd3,
        CFG_INV_C         = 3'd4,
        CFG_INV_D         = 3'd5,
        CFG_SOURCE_CORNER = 3'd6,
        CFG_SOURCE_EXTENT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        operation;
        logic [19:0] dest_x;
        logic [19:0] dest_y;
        logic [15:0] mask_index;
        logic [7:0]  mask_byte;
    } t_pix_req;

    typedef struct packed {
        logic        hit;
        logic [19:0] source_x;
        logic [19:0] source_y;
    } t_pix_res;

endpackage

### rtl/core/iamp_if.sv
// valid/ready stream channel with a typed payload
// no dependencies; payload types come from iamp_pkg at the instance
interface iamp_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/inverse_affine_masked_pixel_map.sv
// Inverse affine masked pixel map. Takes one request per cycle unless a result
// waits to be taken. Each request passes the request register and the stages
// of offset, multiply, sum and bounds check, a pipelined restoring divider
// (one quotient bit per stage) that scales the local position to the mask
// grid, a stage that forms the mask address and the synchronous mask memory
// read. Mask loads travel the same pipeline and write the memory at the stage
// where maps read it, so loads and maps take effect in order and a load
// produces no result. The pipeline stalls as a whole while a result waits to
// be taken.
// depends on iamp_pkg, iamp_if and inverse_affine_masked_pixel_map_macros.svh
`include "inverse_affine_masked_pixel_map_macros.svh"
module inverse_affine_masked_pixel_map #(
    parameter int MASK_DIM       = iamp_pkg::MASK_DIM_DEF,
    parameter int COORD_BITS     = iamp_pkg::COORD_BITS_DEF,
    parameter int COEF_FRAC_BITS = iamp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iamp_if.sink        i_req,
    iamp_if.source      o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [55:0] i_cfg_data
);
    import iamp_pkg::*;

    localparam int LS     = COEF_FRAC_BITS + ORIGIN_FRAC;
    localparam int STORE  = MASK_DIM * MASK_DIM;
    localparam int ADDR_W = $clog2(STORE);
    localparam int MXW    = $clog2(MASK_DIM);
    localparam int NW     = 68;
    localparam int QB     = 8;

    // configuration
    logic signed [31:0] r_origin_x, r_origin_y;
    logic signed [23:0] r_inv_a, r_inv_b, r_inv_c, r_inv_d;
    logic [39:0]        r_corner;
    logic [55:0]        r_extent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_inv_a    <= 24'sd1 <<< COEF_FRAC_BITS;
            r_inv_b    <= '0;
            r_inv_c    <= '0;
            r_inv_d    <= 24'sd1 <<< COEF_FRAC_BITS;
            r_corner   <= '0;
            r_extent   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:      r_origin_x <= i_cfg_data[31:0];
                CFG_ORIGIN_Y:      r_origin_y <= i_cfg_data[31:0];
                CFG_INV_A:         r_inv_a    <= i_cfg_data[23:0];
                CFG_INV_B:         r_inv_b    <= i_cfg_data[23:0];
                CFG_INV_C:         r_inv_c    <= i_cfg_data[23:0];
                CFG_INV_D:         r_inv_d    <= i_cfg_data[23:0];
                CFG_SOURCE_CORNER: r_corner   <= i_cfg_data[39:0];
                CFG_SOURCE_EXTENT: r_extent   <= i_cfg_data;
            endcase
        end
    end

    logic [19:0] w, h;
    logic [8:0]  mw, mh;
    assign w  = r_extent[19:0];
    assign h  = r_extent[39:20];
    assign mw = 9'(r_extent[47:40]) + 9'd1;
    assign mh = 9'(r_extent[55:48]) + 9'd1;

    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || o_res.ready;
    assign i_req.ready = en;

    // stage 1: request register
    logic        r_s1_valid, r_s1_op, r_s1_set;
    logic [19:0] r_s1_x, r_s1_y;
    logic [15:0] r_s1_idx;
    // stage 2: offsets
    logic               r_s2_valid, r_s2_op, r_s2_set;
    logic signed [33:0] r_dx, r_dy;
    logic [15:0]        r_s2_idx;
    // stage 3: products
    logic               r_s3_valid, r_s3_op, r_s3_set;
    logic signed [57:0] r_pa, r_pb, r_pc, r_pd;
    logic [15:0]        r_s3_idx;
    // stage 4: local position
    logic               r_s4_valid, r_s4_op, r_s4_set;
    logic signed [58:0] r_lx, r_ly;
    logic [15:0]        r_s4_idx;
    // divider line, entry 0 is loaded from stage 4
    logic          r_dv_valid [0:QB];
    logic          r_dv_op    [0:QB];
    logic          r_dv_set   [0:QB];
    logic          r_dv_inb   [0:QB];
    logic [19:0]   r_dv_sx    [0:QB];
    logic [19:0]   r_dv_sy    [0:QB];
    logic [NW-1:0] r_rx       [0:QB];
    logic [NW-1:0] r_ry       [0:QB];
    logic [QB-1:0] r_qx       [0:QB];
    logic [QB-1:0] r_qy       [0:QB];
    // address stage
    logic              r_a_valid, r_a_op, r_a_set, r_a_inb;
    logic [ADDR_W-1:0] r_a_addr;
    logic [19:0]       r_a_sx, r_a_sy;
    // memory and output
    logic        r_mask_mem [0:STORE-1];
    logic        r_rd;
    logic        r_out_inb;
    logic [19:0] r_out_sx, r_out_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dv_valid[k] <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_dv_valid[0] <= r_s4_valid;
            for (int k = 1; k <= QB; k++) r_dv_valid[k] <= r_dv_valid[k-1];
            r_a_valid   <= r_dv_valid[QB];
            r_out_valid <= r_a_valid && (t_op'(r_a_op) == OP_MAP);
        end
    end

    // stage 4 to divider entry
    logic [57:0]   ux, uy, ux_int, uy_int;
    logic          inb;
    logic [NW-1:0] nx, ny;
    logic [63:0]   sx_sum, sy_sum;
    assign ux     = r_lx[57:0];
    assign uy     = r_ly[57:0];
    assign ux_int = ux >> LS;
    assign uy_int = uy >> LS;
    assign inb    = !r_lx[58] && !r_ly[58] && (64'(ux_int) < 64'(w)) && (64'(uy_int) < 64'(h));
    assign nx     = NW'(ux) * NW'(mw);
    assign ny     = NW'(uy) * NW'(mh);
    assign sx_sum = 64'(r_corner[19:0]) + 64'(ux_int);
    assign sy_sum = 64'(r_corner[39:20]) + 64'(uy_int);

    // loads reuse the x divider to reduce the index modulo the store size
    logic [NW-1:0] dvx [0:QB-1];
    logic [NW-1:0] dvy [0:QB-1];
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            if (t_op'(r_dv_op[k]) == OP_MAP) begin
                dvx[k] = (NW'(w) << LS) << (QB - 1 - k);
            end else begin
                dvx[k] = NW'(STORE) << (QB - 1 - k);
            end
            dvy[k] = (NW'(h) << LS) << (QB - 1 - k);
        end
    end

    // mask address from the quotients
    logic [MXW-1:0]    mx, my;
    logic [ADDR_W-1:0] map_addr;
    always_comb begin
        mx = (32'(r_qx[QB]) > MASK_DIM - 1) ? MXW'(MASK_DIM - 1) : MXW'(r_qx[QB]);
        my = (32'(r_qy[QB]) > MASK_DIM - 1) ? MXW'(MASK_DIM - 1) : MXW'(r_qy[QB]);
        map_addr = ADDR_W'(32'(my) * MASK_DIM + 32'(mx));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op  <= i_req.payload.operation;
            r_s1_x   <= i_req.payload.dest_x;
            r_s1_y   <= i_req.payload.dest_y;
            r_s1_idx <= i_req.payload.mask_index;
            r_s1_set <= i_req.payload.mask_byte > MASK_THRESHOLD;

            r_s2_op  <= r_s1_op;
            r_s2_set <= r_s1_set;
            r_s2_idx <= r_s1_idx;
            r_dx <= $signed(34'({r_s1_x, 8'h00})) - 34'(r_origin_x);
            r_dy <= $signed(34'({r_s1_y, 8'h00})) - 34'(r_origin_y);

            r_s3_op  <= r_s2_op;
            r_s3_set <= r_s2_set;
            r_s3_idx <= r_s2_idx;
            r_pa <= 58'(r_inv_a) * 58'(r_dx);
            r_pb <= 58'(r_inv_b) * 58'(r_dy);
            r_pc <= 58'(r_inv_c) * 58'(r_dx);
            r_pd <= 58'(r_inv_d) * 58'(r_dy);

            r_s4_op  <= r_s3_op;
            r_s4_set <= r_s3_set;
            r_s4_idx <= r_s3_idx;
            r_lx <= 59'(r_pa) + 59'(r_pb);
            r_ly <= 59'(r_pc) + 59'(r_pd);

            r_dv_op[0]  <= r_s4_op;
            r_dv_set[0] <= r_s4_set;
            r_dv_inb[0] <= inb;
            r_dv_sx[0]  <= 20'(COORD_BITS'(sx_sum));
            r_dv_sy[0]  <= 20'(COORD_BITS'(sy_sum));
            r_rx[0] <= (t_op'(r_s4_op) == OP_MAP) ? nx : NW'(r_s4_idx);
            r_ry[0] <= ny;
            r_qx[0] <= '0;
            r_qy[0] <= '0;

            // one restoring step per stage, most significant quotient bit first
            for (int k = 0; k < QB; k++) begin
                r_dv_op[k+1]  <= r_dv_op[k];
                r_dv_set[k+1] <= r_dv_set[k];
                r_dv_inb[k+1] <= r_dv_inb[k];
                r_dv_sx[k+1]  <= r_dv_sx[k];
                r_dv_sy[k+1]  <= r_dv_sy[k];
                if (r_rx[k] >= dvx[k]) begin
                    r_rx[k+1] <= r_rx[k] - dvx[k];
                    r_qx[k+1] <= r_qx[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_rx[k+1] <= r_rx[k];
                    r_qx[k+1] <= r_qx[k];
                end
                if (r_ry[k] >= dvy[k]) begin
                    r_ry[k+1] <= r_ry[k] - dvy[k];
                    r_qy[k+1] <= r_qy[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_ry[k+1] <= r_ry[k];
                    r_qy[k+1] <= r_qy[k];
                end
            end

            r_a_op   <= r_dv_op[QB];
            r_a_set  <= r_dv_set[QB];
            r_a_inb  <= r_dv_inb[QB];
            r_a_sx   <= r_dv_sx[QB];
            r_a_sy   <= r_dv_sy[QB];
            r_a_addr <= (t_op'(r_dv_op[QB]) == OP_MAP) ? map_addr : ADDR_W'(r_rx[QB]);

            r_out_inb <= r_a_inb;
            r_out_sx  <= r_a_sx;
            r_out_sy  <= r_a_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a_valid && t_op'(r_a_op) == OP_LOAD) begin
                r_mask_mem[r_a_addr] <= r_a_set;
            end
            r_rd <= r_mask_mem[r_a_addr];
        end
    end

    logic hit;
    assign hit = r_out_inb && r_rd;
    assign o_res.valid            = r_out_valid;
    assign o_res.payload.hit      = hit;
    assign o_res.payload.source_x = hit ? r_out_sx : 20'd0;
    assign o_res.payload.source_y = hit ? r_out_sy : 20'd0;

    `IAMP_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, en && r_a_valid && t_op'(r_a_op) == OP_LOAD, !r_out_valid)
    `IAMP_ASSERT_SAME(a_quot_in_mask, i_clk, i_rst_n, r_dv_valid[QB] && t_op'(r_dv_op[QB]) == OP_MAP && r_dv_inb[QB], 9'(r_qx[QB]) < mw && 9'(r_qy[QB]) < mh)
    `IAMP_ASSERT_NEXT(a_stall_holds_line, i_clk, i_rst_n, !en && r_a_valid, r_a_valid && $stable(r_a_addr))

endmodule

### bench/inverse_affine_masked_pixel_map_test.sv
// self-checking bench for the inverse affine masked pixel map: mask loads and pixel maps
// with random idling and back pressure, checked against an in-bench pixel predictor
// depends on iamp_pkg, iamp_if and the inverse_affine_masked_pixel_map top level
module inverse_affine_masked_pixel_map_test;
    timeunit 1ns;
    timeprecision 1ps;
    import iamp_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int LOCAL_FRAC = 24;
    localparam int WATCHDOG   = 5000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN      = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [55:0] i_cfg_data;

    iamp_if #(.t_payload(t_pix_req)) req_ch ();
    iamp_if #(.t_payload(t_pix_res)) res_ch ();

    inverse_affine_masked_pixel_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the registers and the mask
    logic signed [31:0] org_x, org_y;
    logic signed [23:0] coef_a, coef_b, coef_c, coef_d;
    logic [39:0]        corner;
    logic [55:0]        extent;
    bit                 mask_store [65536];
    bit                 mask_known [65536];

    t_pix_res pending_pixels [$];
    int       errors, maps_sent, loads_sent, hits_seen, results_seen;
    bit       calm, holding;
    int       quiet_cycles;

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // mask address that a map reads, or -1 when the pixel falls outside the rectangle
    function automatic longint mask_slot(t_pix_req r, output logic [19:0] sx,
                                         output logic [19:0] sy);
        longint dx, dy, lx, ly, span_x, span_y, mw, mh, mx, my;
        dx = longint'(r.dest_x) * 256 - longint'(org_x);
        dy = longint'(r.dest_y) * 256 - longint'(org_y);
        lx = longint'(coef_a) * dx + longint'(coef_b) * dy;
        ly = longint'(coef_c) * dx + longint'(coef_d) * dy;
        span_x = longint'(extent[19:0]) <<< LOCAL_FRAC;
        span_y = longint'(extent[39:20]) <<< LOCAL_FRAC;
        mw = longint'(extent[47:40]) + 1;
        mh = longint'(extent[55:48]) + 1;
        sx = corner[19:0] + 20'(lx >>> LOCAL_FRAC);
        sy = corner[39:20] + 20'(ly >>> LOCAL_FRAC);
        if (lx < 0 || ly < 0 || lx >= span_x || ly >= span_y) return -1;
        mx = (lx * mw) / span_x;
        my = (ly * mh) / span_y;
        if (mx > mw - 1) mx = mw - 1;
        if (my > mh - 1) my = mh - 1;
        return my * 256 + mx;
    endfunction

    function automatic t_pix_res predict_pixel(t_pix_req r);
        t_pix_res res;
        logic [19:0] sx, sy;
        longint slot;
        slot = mask_slot(r, sx, sy);
        res = '0;
        if (slot >= 0 && mask_store[slot]) begin
            res.hit = 1'b1;
            res.source_x = sx;
            res.source_y = sy;
        end
        return res;
    endfunction

    task automatic send_request(t_pix_req r);
        @(negedge i_clk);
        while (!calm && !holding && $urandom_range(0, 99) < 22) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        if (t_op'(r.operation) == OP_MAP) begin
            pending_pixels = {pending_pixels, predict_pixel(r)};
            maps_sent++;
        end else begin
            mask_store[r.mask_index] = (r.mask_byte > MASK_THRESHOLD);
            mask_known[r.mask_index] = 1'b1;
            loads_sent++;
        end
    endtask

    task automatic send_load(logic [15:0] idx, logic [7:0] value);
        t_pix_req r;
        r = '0;
        r.operation = OP_LOAD;
        r.mask_index = idx;
        r.mask_byte = value;
        send_request(r);
    endtask

    // a map that would read an unloaded mask entry gets that entry loaded first
    task automatic send_map(logic [19:0] x, logic [19:0] y);
        t_pix_req r;
        logic [19:0] sx, sy;
        longint slot;
        r = '0;
        r.operation = OP_MAP;
        r.dest_x = x;
        r.dest_y = y;
        r.mask_index = 16'($urandom);
        r.mask_byte = 8'($urandom);
        slot = mask_slot(r, sx, sy);
        if (slot >= 0 && !mask_known[slot]) send_load(16'(slot), 8'($urandom));
        send_request(r);
    endtask

    task automatic release_request();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // loads give no result, so wait after the last pixel until the pipeline has drained
    task automatic wait_idle();
        release_request();
        wait (pending_pixels.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [55:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_ORIGIN_X:      org_x  = value[31:0];
            CFG_ORIGIN_Y:      org_y  = value[31:0];
            CFG_INV_A:         coef_a = value[23:0];
            CFG_INV_B:         coef_b = value[23:0];
            CFG_INV_C:         coef_c = value[23:0];
            CFG_INV_D:         coef_d = value[23:0];
            CFG_SOURCE_CORNER: corner = value[39:0];
            default:           extent = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_transform(logic signed [31:0] ox, logic signed [31:0] oy,
                                 logic signed [23:0] a, logic signed [23:0] b,
                                 logic signed [23:0] c, logic signed [23:0] d,
                                 logic [39:0] cor, logic [55:0] ext);
        wait_idle();
        write_register(CFG_ORIGIN_X, 56'(unsigned'(ox)));
        write_register(CFG_ORIGIN_Y, 56'(unsigned'(oy)));
        write_register(CFG_INV_A, 56'(unsigned'(a)));
        write_register(CFG_INV_B, 56'(unsigned'(b)));
        write_register(CFG_INV_C, 56'(unsigned'(c)));
        write_register(CFG_INV_D, 56'(unsigned'(d)));
        write_register(CFG_SOURCE_CORNER, 56'(cor));
        write_register(CFG_SOURCE_EXTENT, ext);
    endtask

    function automatic logic [55:0] make_extent(int w, int h, int mwf, int mhf);
        return {8'(mhf), 8'(mwf), 20'(h), 20'(w)};
    endfunction

    // reset values: zero width, so every pixel misses
    task automatic test_reset_state();
        send_load(16'h0000, 8'd255);
        send_load(16'hffff, 8'd0);
        send_map(20'd0, 20'd0);
        send_map(20'hfffff, 20'hfffff);
    endtask

    task automatic test_directed_edges();
        // identity move with a 16 by 16 rectangle and mask
        set_transform(32'sd0, 32'sd0, 24'sd65536, 24'sd0, 24'sd0, 24'sd65536,
                      {20'd100, 20'd200}, make_extent(16, 16, 15, 15));
        send_load(16'd0, 8'd129);
        send_load(16'd15 * 256 + 16'd15, 8'd128);
        send_load(16'd15, 8'd200);
        send_map(20'd0, 20'd0);
        send_map(20'd15, 20'd15);
        send_map(20'd15, 20'd0);
        send_map(20'd16, 20'd3);
        send_map(20'd3, 20'd16);
        // mask as wide as the store, corner wraps past the coordinate range
        set_transform(-32'sd256, 32'sd128, 24'sd32768, 24'sd0, 24'sd0, 24'sd65536,
                      {20'hffff0, 20'hfffff}, make_extent(4, 4, 255, 255));
        send_map(20'd0, 20'd0);
        send_map(20'd7, 20'd3);
        send_map(20'd2, 20'd4);
        // absurd coefficients and extreme origins
        set_transform(32'sh80000000, 32'sh7fffffff, 24'sh800000, 24'sh7fffff,
                      24'sh7fffff, 24'sh800000, 40'hff_ffff_ffff, 56'hff_ffff_ffff_ffff);
        send_map(20'hfffff, 20'd0);
        send_map(20'd0, 20'hfffff);
        send_map(20'h80000, 20'h7ffff);
    endtask

    task automatic random_phase(int count);
        int w, h;
        logic signed [31:0] ox, oy;
        logic signed [23:0] a, b, c, d;
        ox = (int'($urandom_range(0, 9000)) - 1000) * 256 + int'($urandom_range(0, 255));
        oy = (int'($urandom_range(0, 9000)) - 1000) * 256 + int'($urandom_range(0, 255));
        w = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 48);
        h = $urandom_range(1, 48);
        if ($urandom_range(0, 9) == 0) begin
            {a, b, c, d} = {24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
        end else begin
            a = 24'(65536 + int'($urandom_range(0, 60000)) - 30000);
            b = 24'(int'($urandom_range(0, 16000)) - 8000);
            c = 24'(int'($urandom_range(0, 16000)) - 8000);
            d = 24'(65536 + int'($urandom_range(0, 60000)) - 30000);
        end
        set_transform(ox, oy, a, b, c, d, {20'($urandom), 20'($urandom)},
                      make_extent(w, h, $urandom_range(0, 255), $urandom_range(0, 255)));
        repeat (count) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_load(16'($urandom), 8'($urandom));
            else if (pick < 25)
                send_map(20'($urandom), 20'($urandom));
            else
                send_map(20'((ox >>> 8) + int'($urandom_range(0, 70)) - 8),
                         20'((oy >>> 8) + int'($urandom_range(0, 70)) - 8));
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 8; p++) begin
            calm = (p == 3);
            random_phase(120);
        end
        calm = 1'b0;
    endtask

    // receiver holds off long enough for the pipeline to fill and stall requests
    task automatic test_back_pressure();
        set_transform(32'sd0, 32'sd0, 24'sd65536, 24'sd0, 24'sd0, 24'sd65536,
                      {20'd7, 20'd9}, make_extent(32, 32, 31, 31));
        fork
            begin
                holding = 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
                holding = 1'b0;
            end
        join_none
        repeat (60) send_map(20'($urandom_range(0, 35)), 20'($urandom_range(0, 35)));
    endtask

    always @(negedge i_clk) begin
        res_ch.ready <= !holding && (calm || $urandom_range(0, 99) >= 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                t_pix_res want;
                want = pending_pixels.pop_front();
                if (res_ch.payload.hit) hits_seen++;
                if (res_ch.payload.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, res_ch.payload.hit);
                    errors++;
                end
                if (res_ch.payload.source_x !== want.source_x) begin
                    $error("source_x: expected %0d, got %0d", want.source_x,
                           res_ch.payload.source_x);
                    errors++;
                end
                if (res_ch.payload.source_y !== want.source_y) begin
                    $error("source_y: expected %0d, got %0d", want.source_y,
                           res_ch.payload.source_y);
                    errors++;
                end
            end
        end
    end

    // stall detector: no request and no result taken for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG) begin
            $display("timeout with %0d results outstanding", pending_pixels.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        org_x = 0;
        org_y = 0;
        coef_a = 24'sd65536;
        coef_b = 0;
        coef_c = 0;
        coef_d = 24'sd65536;
        corner = '0;
        extent = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_edges();
        test_random_phases();
        test_back_pressure();
        wait_idle();

        $display("covered %0d pixel maps and %0d mask loads; %0d results, %0d hits",
                 maps_sent, loads_sent, results_seen, hits_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
